>>> rtl/hfe3bcd_pkg.sv
package hfe3bcd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned PosW  = 3;
	localparam int unsigned CntW  = 4;

	localparam logic [ByteW-1:0] OpcLowMask   = 8'h0F;
	localparam logic [ByteW-1:0] OpcNop       = 8'h0F;
	localparam logic [ByteW-1:0] OpcSetIndex  = 8'h8F;
	localparam logic [ByteW-1:0] OpcSetRate   = 8'h4F;
	localparam logic [ByteW-1:0] OpcSkipBits  = 8'hCF;
	localparam logic [ByteW-1:0] OpcRand      = 8'h2F;

	localparam logic [CntW-1:0] SkipSat = 4'd8;

	localparam int unsigned QueueDepthDef = 2;

	// One burst of cells for the back end: bits first..7 of data.
	typedef struct packed {
		logic [ByteW-1:0] data;
		logic [PosW-1:0]  first;
		logic             is_weak;
		logic             index;
	} cmd_t;

endpackage

>>> rtl/hfe3bcd_front.sv
module hfe3bcd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [hfe3bcd_pkg::ByteW-1:0] data_byte,
	input  logic                        track_start,
	output logic                        push,
	output hfe3bcd_pkg::cmd_t           push_cmd,
	input  logic                        queue_full
);

	typedef enum logic [1:0] {
		PH_IDLE     = 2'd0,
		PH_RATE_ARG = 2'd1,
		PH_SKIP_CNT = 2'd2,
		PH_SKIP_DAT = 2'd3
	} phase_t;

	phase_t                         phase_q;
	logic [hfe3bcd_pkg::CntW-1:0]   skip_q;
	logic                           pend_q;

	logic                           accept;
	phase_t                         phase_cur;
	logic                           pend_cur;
	phase_t                         phase_nxt;
	logic [hfe3bcd_pkg::CntW-1:0]   skip_nxt;
	logic                           pend_nxt;
	logic                           emit;
	hfe3bcd_pkg::cmd_t              cmd;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		// A track start clears the decoder before this byte is decoded.
		phase_cur   = track_start ? PH_IDLE : phase_q;
		pend_cur    = track_start ? 1'b0 : pend_q;
		phase_nxt   = phase_cur;
		skip_nxt    = track_start ? '0 : skip_q;
		pend_nxt    = pend_cur;
		emit        = 1'b0;
		cmd.data    = data_byte;
		cmd.first   = '0;
		cmd.is_weak = 1'b0;
		cmd.index   = pend_cur;
		case (phase_cur)
			PH_RATE_ARG: begin
				phase_nxt = PH_IDLE;
			end
			PH_SKIP_CNT: begin
				skip_nxt  = (data_byte >= 8'(hfe3bcd_pkg::SkipSat)) ?
					hfe3bcd_pkg::SkipSat : data_byte[hfe3bcd_pkg::CntW-1:0];
				phase_nxt = PH_SKIP_DAT;
			end
			PH_SKIP_DAT: begin
				// A saturated count of eight leaves no cells to send.
				emit      = !skip_q[hfe3bcd_pkg::CntW-1];
				cmd.first = skip_q[hfe3bcd_pkg::PosW-1:0];
				skip_nxt  = '0;
				phase_nxt = PH_IDLE;
			end
			default: begin
				if ((data_byte & hfe3bcd_pkg::OpcLowMask) == hfe3bcd_pkg::OpcLowMask) begin
					case (data_byte)
						hfe3bcd_pkg::OpcSetIndex: pend_nxt  = 1'b1;
						hfe3bcd_pkg::OpcSetRate:  phase_nxt = PH_RATE_ARG;
						hfe3bcd_pkg::OpcSkipBits: phase_nxt = PH_SKIP_CNT;
						hfe3bcd_pkg::OpcRand: begin
							emit        = 1'b1;
							cmd.is_weak = 1'b1;
							cmd.data    = '0;
						end
						default: emit = 1'b0;
					endcase
				end else begin
					emit = 1'b1;
				end
			end
		endcase
		if (emit) begin
			pend_nxt = 1'b0;
		end
	end

	assign push     = accept && emit;
	assign push_cmd = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			skip_q  <= '0;
			pend_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			skip_q  <= skip_nxt;
			pend_q  <= pend_nxt;
		end
	end

endmodule

>>> rtl/hfe3bcd_queue.sv
module hfe3bcd_queue #(
	parameter int unsigned DEPTH = hfe3bcd_pkg::QueueDepthDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hfe3bcd_pkg::cmd_t push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              cmd_valid,
	output hfe3bcd_pkg::cmd_t cmd
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	hfe3bcd_pkg::cmd_t  mem_q [DEPTH];
	logic [PtrW-1:0]    wr_q;
	logic [PtrW-1:0]    rd_q;
	logic [CntW-1:0]    cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (cnt_q == CntW'(DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = mem_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CntW'(do_push) - CntW'(do_pop);
		end
	end

	property p_no_lost_push;
		@(posedge clk) disable iff (!arst_n) push |-> !full;
	endproperty
	a_no_lost_push: assert property (p_no_lost_push)
		else $error("command pushed into a full queue");

	property p_cnt_bound;
		@(posedge clk) disable iff (!arst_n) cnt_q <= CntW'(DEPTH);
	endproperty
	a_cnt_bound: assert property (p_cnt_bound)
		else $error("queue count beyond depth");

	property p_cnt_step;
		@(posedge clk) disable iff (!arst_n)
			(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1);
	endproperty
	a_cnt_step: assert property (p_cnt_step)
		else $error("queue count did not follow a push");

endmodule

>>> rtl/hfe3bcd_back.sv
module hfe3bcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  hfe3bcd_pkg::cmd_t cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              bit_value,
	output logic              index_mark,
	output logic              weak_cell,
	output logic              last_cell
);

	logic                          busy_q;
	hfe3bcd_pkg::cmd_t             cur_q;
	logic [hfe3bcd_pkg::PosW-1:0]  pos_q;
	logic                          out_valid_q;
	logic                          bit_q;
	logic                          index_q;
	logic                          weak_q;
	logic                          last_q;

	logic                          advance;
	logic                          final_cell;

	assign advance    = !out_valid_q || !out_stall;
	assign final_cell = busy_q && (pos_q == '1);
	// Load the next burst while the last cell of this one goes out.
	assign pop        = cmd_valid && (!busy_q || (advance && final_cell));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				pos_q  <= cmd.first;
			end else if (advance && busy_q) begin
				pos_q <= pos_q + 1'b1;
				if (final_cell) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end else if (advance && busy_q) begin
			cur_q.index <= 1'b0;
		end
		if (advance && busy_q) begin
			bit_q   <= cur_q.data[pos_q];
			index_q <= cur_q.index;
			weak_q  <= cur_q.is_weak;
			last_q  <= final_cell;
		end
	end

	assign out_valid  = out_valid_q;
	assign bit_value  = bit_q;
	assign index_mark = index_q;
	assign weak_cell  = weak_q;
	assign last_cell  = last_q;

	property p_weak_zero;
		@(posedge clk) disable iff (!arst_n) (out_valid_q && weak_q) |-> !bit_q;
	endproperty
	a_weak_zero: assert property (p_weak_zero)
		else $error("weak cell carries a one");

	property p_pop_at_end;
		@(posedge clk) disable iff (!arst_n) pop |-> (!busy_q || final_cell);
	endproperty
	a_pop_at_end: assert property (p_pop_at_end)
		else $error("burst replaced before its last cell");

	property p_burst_continues;
		@(posedge clk) disable iff (!arst_n)
			(advance && busy_q && !final_cell) |=> (busy_q && out_valid_q);
	endproperty
	a_burst_continues: assert property (p_burst_continues)
		else $error("burst stopped before bit seven");

endmodule

>>> rtl/hfe3_track_bitcell_decoder_core.sv
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   data_byte[7:0], track_start
// output    out        out_valid/out_stall bit_value, index_mark, weak_cell, last_cell
//
// A byte producing cells yields one cell per cycle unless the output stalls, up to eight,
// set by the single cell register of the back end; opcode and argument bytes send none.
// Bytes keep arriving through the command queue while cells are sent.
// Reset clears the decode phase, skip count, pending index and the queue.
// Output stall holds the cell register; input stall rises only when the queue is full.
module hfe3_track_bitcell_decoder_core #(
	parameter int unsigned QUEUE_DEPTH = hfe3bcd_pkg::QueueDepthDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [hfe3bcd_pkg::ByteW-1:0] data_byte,
	input  logic                          track_start,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          bit_value,
	output logic                          index_mark,
	output logic                          weak_cell,
	output logic                          last_cell
);

	logic              push;
	hfe3bcd_pkg::cmd_t push_cmd;
	logic              full;
	logic              pop;
	logic              cmd_valid;
	hfe3bcd_pkg::cmd_t cmd;

	hfe3bcd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.track_start(track_start),
		.push       (push),
		.push_cmd   (push_cmd),
		.queue_full (full)
	);

	hfe3bcd_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.cmd_valid(cmd_valid),
		.cmd      (cmd)
	);

	hfe3bcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bit_value (bit_value),
		.index_mark(index_mark),
		.weak_cell (weak_cell),
		.last_cell (last_cell)
	);

endmodule
